@@ src/cgts_pkg.sv @@
// Shared types, codes and constants of the color gradient table sampler.
// Used by the controller, the datapath and the top level; no dependencies.
package cgts_pkg;

	localparam int MAX_KEYS_DEF = 16;
	localparam int TIME_W       = 16;
	localparam int CHAN_W       = 16;
	localparam int COLOR_W      = 64;
	localparam int COUNT_W      = 9;
	localparam int INDEX_W      = 8;
	localparam int ACTION_W     = 3;
	localparam int STATUS_W     = 2;
	localparam int S_DATA_W     = 96;
	localparam int M_DATA_W     = 96;
	localparam int APB_ADDR_W   = 5;
	localparam int APB_DATA_W   = 64;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_SAMPLE = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_SET    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_GET    = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_LEFT    = 2'd0;
	localparam logic [1:0] REG_RIGHT   = 2'd1;
	localparam logic [1:0] REG_SPACING = 2'd2;

	localparam logic [COLOR_W-1:0] LEFT_RESET    = '0;
	localparam logic [COLOR_W-1:0] RIGHT_RESET   = '1;
	localparam logic [COLOR_W-1:0] WHITE         = '1;
	localparam logic [TIME_W-1:0]  TIME_ONE      = 16'hFFFF;
	localparam logic [TIME_W-1:0]  SPACING_RESET = 16'd66;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_SMP0_W, ST_SCAN_RD, ST_SCAN_W, ST_NXT_W, ST_MUL,
		ST_DIV, ST_ACC, ST_ADD_RD, ST_ADD_W, ST_ADD_CHK, ST_SHF, ST_SHF_W,
		ST_RM, ST_RM_W, ST_SET, ST_GET_RD, ST_GET_W, ST_DONE
	} state_t;

	typedef enum logic [1:0] {RSEL_I, RSEL_IM1, RSEL_IP1} rsel_t;
	typedef enum logic {WSEL_INPUT, WSEL_RDATA} wsel_t;
	typedef enum logic [2:0] {
		IOP_HOLD, IOP_ZERO, IOP_LAST, IOP_N, IOP_IDX, IOP_INC, IOP_DEC
	} iop_t;
	typedef enum logic [1:0] {NOP_HOLD, NOP_INC, NOP_DEC} nop_t;
	typedef enum logic [2:0] {RES_ZERO, RES_WHITE, RES_COLOR, RES_KEY, RES_KEEP} res_src_t;

	typedef struct packed {
		logic                load;
		logic                rd_en;
		rsel_t               rd_sel;
		logic                wr_en;
		wsel_t               wr_sel;
		iop_t                i_op;
		nop_t                n_op;
		logic                add_init;
		logic                add_cmp;
		logic                seg_cap;
		logic                nxt_cap;
		logic                mul_start;
		logic                div_step;
		logic                acc;
		logic                res_set;
		logic [STATUS_W-1:0] res_status;
		res_src_t            res_src;
		logic                out_load;
	} cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                n_zero;
		logic                n_one;
		logic                n_le2;
		logic                full;
		logic                idx_ge_n;
		logic                i_eq_n;
		logic                i_is_last;
		logic                i1_ge_n;
		logic                i_eq_pos;
		logic                t_lt_rtime;
		logic                close;
		logic                span_pos;
		logic                div_last;
		logic                ch_last;
		logic                out_free;
	} sts_t;

endpackage

@@ src/cgts_ctrl.sv @@
// Sequencer of the gradient table sampler: one item at a time through search,
// shift, interpolate and divide steps. Depends on cgts_pkg.
module cgts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  cgts_pkg::sts_t sts,
	output cgts_pkg::cmd_t cmd
);
	import cgts_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cmd.i_op = IOP_ZERO;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (sts.action)
					ACT_SAMPLE: begin
						if (sts.n_zero) begin
							cmd.res_set = 1'b1;
							cmd.res_src = RES_WHITE;
							state_d     = ST_DONE;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = ST_SMP0_W;
						end
					end
					ACT_ADD: begin
						cmd.add_init = 1'b1;
						state_d      = ST_ADD_RD;
					end
					ACT_REMOVE: begin
						cmd.res_set = 1'b1;
						if (sts.n_le2) begin
							cmd.res_status = STAT_REFUSED;
							state_d        = ST_DONE;
						end else if (sts.idx_ge_n) begin
							cmd.res_status = STAT_RANGE;
							state_d        = ST_DONE;
						end else begin
							cmd.res_set = 1'b0;
							cmd.i_op    = IOP_IDX;
							state_d     = ST_RM;
						end
					end
					ACT_SET, ACT_GET: begin
						if (sts.idx_ge_n) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = STAT_RANGE;
							state_d        = ST_DONE;
						end else begin
							cmd.i_op = IOP_IDX;
							state_d  = (sts.action == ACT_SET) ? ST_SET : ST_GET_RD;
						end
					end
					default: begin
						cmd.res_set    = 1'b1;
						cmd.res_status = STAT_REFUSED;
						state_d        = ST_DONE;
					end
				endcase
			end
			// First key decides the below-range case
			ST_SMP0_W: begin
				if (sts.n_one || sts.t_lt_rtime) begin
					cmd.res_set = 1'b1;
					cmd.res_src = RES_COLOR;
					state_d     = ST_DONE;
				end else begin
					cmd.i_op = IOP_LAST;
					state_d  = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_SCAN_W;
			end
			// Walk down from the last key to the segment start
			ST_SCAN_W: begin
				if (!sts.t_lt_rtime) begin
					if (sts.i_is_last) begin
						cmd.res_set = 1'b1;
						cmd.res_src = RES_COLOR;
						state_d     = ST_DONE;
					end else begin
						cmd.seg_cap = 1'b1;
						cmd.rd_en   = 1'b1;
						cmd.rd_sel  = RSEL_IP1;
						state_d     = ST_NXT_W;
					end
				end else begin
					cmd.i_op = IOP_DEC;
					state_d  = ST_SCAN_RD;
				end
			end
			ST_NXT_W: begin
				if (!sts.span_pos) begin
					cmd.res_set = 1'b1;
					cmd.res_src = RES_WHITE;
					state_d     = ST_DONE;
				end else begin
					cmd.nxt_cap = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (sts.ch_last) begin
					cmd.res_set = 1'b1;
					cmd.res_src = RES_KEEP;
					state_d     = ST_DONE;
				end else begin
					state_d = ST_MUL;
				end
			end
			// Spacing check and insert position over all keys
			ST_ADD_RD: begin
				if (sts.i_eq_n) begin
					state_d = ST_ADD_CHK;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_ADD_W;
				end
			end
			ST_ADD_W: begin
				cmd.add_cmp = 1'b1;
				cmd.i_op    = IOP_INC;
				state_d     = ST_ADD_RD;
			end
			ST_ADD_CHK: begin
				if (sts.close || sts.full) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = STAT_REFUSED;
					state_d        = ST_DONE;
				end else begin
					cmd.i_op = IOP_N;
					state_d  = ST_SHF;
				end
			end
			// Shift keys up to open the insert slot
			ST_SHF: begin
				if (sts.i_eq_pos) begin
					cmd.wr_en   = 1'b1;
					cmd.n_op    = NOP_INC;
					cmd.res_set = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RSEL_IM1;
					state_d    = ST_SHF_W;
				end
			end
			ST_SHF_W: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WSEL_RDATA;
				cmd.i_op   = IOP_DEC;
				state_d    = ST_SHF;
			end
			// Shift keys down over the removed one
			ST_RM: begin
				if (sts.i1_ge_n) begin
					cmd.n_op    = NOP_DEC;
					cmd.res_set = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RSEL_IP1;
					state_d    = ST_RM_W;
				end
			end
			ST_RM_W: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WSEL_RDATA;
				cmd.i_op   = IOP_INC;
				state_d    = ST_RM;
			end
			ST_SET: begin
				cmd.wr_en   = 1'b1;
				cmd.res_set = 1'b1;
				state_d     = ST_DONE;
			end
			ST_GET_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_GET_W;
			end
			ST_GET_W: begin
				cmd.res_set = 1'b1;
				cmd.res_src = RES_KEY;
				state_d     = ST_DONE;
			end
			// Hand the result to the output register once it is free
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/cgts_datapath.sv @@
// Datapath of the gradient table sampler: key memory, scan index, multiplier,
// serial divider and output register. Depends on cgts_pkg.
module cgts_datapath #(
	parameter int MAX_KEYS = cgts_pkg::MAX_KEYS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cgts_pkg::cmd_t                   cmd,
	output cgts_pkg::sts_t                   sts,
	input  logic [cgts_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic [cgts_pkg::TIME_W-1:0]      min_spacing,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [cgts_pkg::M_DATA_W-1:0]    m_tdata
);
	import cgts_pkg::*;

	localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_W = $clog2(MAX_KEYS + 1);

	function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] c,
			input logic [1:0] k);
		logic [CHAN_W-1:0] v;
		case (k)
			2'd0:    v = c[63:48];
			2'd1:    v = c[47:32];
			2'd2:    v = c[31:16];
			default: v = c[15:0];
		endcase
		return v;
	endfunction

	// Captured item
	logic [ACTION_W-1:0] action_q;
	logic [TIME_W-1:0]   t_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [COLOR_W-1:0]  color_in_q;

	logic [CNT_W-1:0] n_q, i_q, pos_q;
	logic             close_q, found_q;

	// Key memory
	logic [TIME_W-1:0]  key_time_mem  [MAX_KEYS];
	logic [COLOR_W-1:0] key_color_mem [MAX_KEYS];
	logic [MAX_KEYS-1:0] key_vld_q;
	logic [TIME_W-1:0]  rtime_raw_q;
	logic [COLOR_W-1:0] rcolor_raw_q;
	logic               rvld_q;
	logic [IDX_W-1:0]   raddr_q;
	logic [CNT_W-1:0]   raddr_full;
	logic [IDX_W-1:0]   raddr, waddr;
	logic [TIME_W-1:0]  rd_time, wtime;
	logic [COLOR_W-1:0] rd_color, wcolor;

	// Interpolation
	logic [COLOR_W-1:0] ca_q, cb_q;
	logic [TIME_W-1:0]  t0_q, span_q, off_q, a_q;
	logic [1:0]         ch_q;
	logic               neg_q;
	logic [31:0]        dvd_q;
	logic [15:0]        rem_q;
	logic [4:0]         div_cnt_q;
	logic [16:0]        span_diff, ch_diff, rem_sh;
	logic [15:0]        ch_mag, acc_val;
	logic [32:0]        acc_sum;
	logic               ge;

	// Result staging and output
	logic [STATUS_W-1:0] res_status_q, m_status_q;
	logic [TIME_W-1:0]   res_time_q, m_time_q;
	logic [COLOR_W-1:0]  res_color_q, m_color_q;
	logic [COUNT_W-1:0]  m_count_q;
	logic                m_valid_q;

	// Read and write addresses
	always_comb begin
		case (cmd.rd_sel)
			RSEL_IM1: raddr_full = i_q - CNT_W'(1);
			RSEL_IP1: raddr_full = i_q + CNT_W'(1);
			default:  raddr_full = i_q;
		endcase
	end
	assign raddr = raddr_full[IDX_W-1:0];
	assign waddr = i_q[IDX_W-1:0];

	// Untouched entries read as their reset contents
	always_comb begin
		if (rvld_q) begin
			rd_time  = rtime_raw_q;
			rd_color = rcolor_raw_q;
		end else if (raddr_q == IDX_W'(1)) begin
			rd_time  = TIME_ONE;
			rd_color = RIGHT_RESET;
		end else if (raddr_q == IDX_W'(0)) begin
			rd_time  = '0;
			rd_color = LEFT_RESET;
		end else begin
			rd_time  = '0;
			rd_color = '0;
		end
	end

	assign wtime  = (cmd.wr_sel == WSEL_INPUT) ? t_q : rd_time;
	assign wcolor = (cmd.wr_sel == WSEL_INPUT) ? color_in_q : rd_color;

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			key_time_mem[waddr]  <= wtime;
			key_color_mem[waddr] <= wcolor;
		end
		if (cmd.rd_en) begin
			rtime_raw_q  <= key_time_mem[raddr];
			rcolor_raw_q <= key_color_mem[raddr];
			rvld_q       <= key_vld_q[raddr];
			raddr_q      <= raddr;
		end
	end

	// Mark entries as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_vld_q <= '0;
		end else if (cmd.wr_en) begin
			key_vld_q[waddr] <= 1'b1;
		end
	end

	// Key count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CNT_W'(2);
		end else begin
			case (cmd.n_op)
				NOP_INC: n_q <= n_q + CNT_W'(1);
				NOP_DEC: n_q <= n_q - CNT_W'(1);
				default: n_q <= n_q;
			endcase
		end
	end

	assign span_diff = {1'b0, rd_time} - {1'b0, t0_q};
	assign ch_diff   = {1'b0, chan_of(cb_q, ch_q)} - {1'b0, chan_of(ca_q, ch_q)};
	assign ch_mag    = ch_diff[16] ? 16'(-ch_diff) : ch_diff[15:0];
	assign rem_sh    = {rem_q, dvd_q[31]};
	assign ge        = (rem_sh >= {1'b0, span_q});

	// Saturate a +/- quotient into the channel range
	always_comb begin
		acc_sum = {17'b0, a_q} + {1'b0, dvd_q};
		if (neg_q) begin
			acc_val = (dvd_q > {16'b0, a_q}) ? 16'd0 : (a_q - dvd_q[15:0]);
		end else begin
			acc_val = (acc_sum > 33'd65535) ? 16'hFFFF : acc_sum[15:0];
		end
	end

	// Item capture, scan index, search and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= s_tdata[2:0];
			t_q        <= s_tdata[18:3];
			idx_q      <= s_tdata[26:19];
			color_in_q <= {s_tdata[42:27], s_tdata[58:43], s_tdata[74:59], s_tdata[90:75]};
		end
		case (cmd.i_op)
			IOP_ZERO: i_q <= '0;
			IOP_LAST: i_q <= n_q - CNT_W'(1);
			IOP_N:    i_q <= n_q;
			IOP_IDX:  i_q <= CNT_W'(idx_q);
			IOP_INC:  i_q <= i_q + CNT_W'(1);
			IOP_DEC:  i_q <= i_q - CNT_W'(1);
			default:  i_q <= i_q;
		endcase
		if (cmd.add_init) begin
			close_q <= 1'b0;
			found_q <= 1'b0;
			pos_q   <= n_q;
		end
		if (cmd.add_cmp) begin
			if (((rd_time > t_q) ? (rd_time - t_q) : (t_q - rd_time)) < min_spacing) begin
				close_q <= 1'b1;
			end
			if (!found_q && (rd_time > t_q)) begin
				found_q <= 1'b1;
				pos_q   <= i_q;
			end
		end
		if (cmd.seg_cap) begin
			ca_q <= rd_color;
			t0_q <= rd_time;
		end
		if (cmd.nxt_cap) begin
			cb_q   <= rd_color;
			span_q <= span_diff[15:0];
			off_q  <= t_q - t0_q;
			ch_q   <= 2'd0;
		end
		// Multiply magnitude by the offset, then divide serially
		if (cmd.mul_start) begin
			a_q       <= chan_of(ca_q, ch_q);
			neg_q     <= ch_diff[16];
			dvd_q     <= ch_mag * off_q;
			rem_q     <= '0;
			div_cnt_q <= 5'd31;
		end
		if (cmd.div_step) begin
			rem_q     <= ge ? 16'(rem_sh - {1'b0, span_q}) : rem_sh[15:0];
			dvd_q     <= {dvd_q[30:0], ge};
			div_cnt_q <= div_cnt_q - 5'd1;
		end
		if (cmd.acc) begin
			case (ch_q)
				2'd0:    res_color_q[63:48] <= acc_val;
				2'd1:    res_color_q[47:32] <= acc_val;
				2'd2:    res_color_q[31:16] <= acc_val;
				default: res_color_q[15:0]  <= acc_val;
			endcase
			ch_q <= ch_q + 2'd1;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_src)
				RES_WHITE: begin
					res_time_q  <= '0;
					res_color_q <= WHITE;
				end
				RES_COLOR: begin
					res_time_q  <= '0;
					res_color_q <= rd_color;
				end
				RES_KEY: begin
					res_time_q  <= rd_time;
					res_color_q <= rd_color;
				end
				RES_KEEP: begin
					res_time_q <= '0;
				end
				default: begin
					res_time_q  <= '0;
					res_color_q <= '0;
				end
			endcase
		end
		if (cmd.out_load) begin
			m_status_q <= res_status_q;
			m_time_q   <= res_time_q;
			m_color_q  <= res_color_q;
			m_count_q  <= COUNT_W'(n_q);
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, m_count_q, m_color_q[15:0], m_color_q[31:16],
		m_color_q[47:32], m_color_q[63:48], m_time_q, m_status_q};

	// Status toward the controller
	always_comb begin
		sts            = '0;
		sts.action     = action_q;
		sts.n_zero     = (n_q == '0);
		sts.n_one      = (n_q == CNT_W'(1));
		sts.n_le2      = (n_q <= CNT_W'(2));
		sts.full       = (n_q >= CNT_W'(MAX_KEYS));
		sts.idx_ge_n   = ({1'b0, idx_q} >= COUNT_W'(n_q));
		sts.i_eq_n     = (i_q == n_q);
		sts.i_is_last  = (({1'b0, i_q} + (CNT_W+1)'(1)) == {1'b0, n_q});
		sts.i1_ge_n    = (({1'b0, i_q} + (CNT_W+1)'(1)) >= {1'b0, n_q});
		sts.i_eq_pos   = (i_q == pos_q);
		sts.t_lt_rtime = (t_q < rd_time);
		sts.close      = close_q;
		sts.span_pos   = !span_diff[16] && (span_diff[15:0] != '0);
		sts.div_last   = (div_cnt_q == '0);
		sts.ch_last    = (ch_q == 2'd3);
		sts.out_free   = !m_valid_q || m_tready;
	end

endmodule

@@ src/color_gradient_table_sampler_core.sv @@
// Color gradient table sampler: keeps up to MAX_KEYS sorted gradient keys and
// samples, adds, removes, sets or reads them, one item at a time.
// Stream in (s_tvalid/s_tready/s_tdata) carries one action; stream out
// (m_tvalid/m_tready/m_tdata) returns exactly one result item per action.
// The APB port holds left_color (0x00), right_color (0x08) and min_spacing
// (0x10); write it only while the block is idle.
// Flow: an item is taken only in the idle state. A sample searches down from
// the last key for its segment and, when it interpolates, works on each
// channel in turn (one multiply, a 32-step restoring divide and a saturating
// add per channel through one shared unit). Add scans all keys and shifts keys
// up, remove shifts keys down, set and get touch one key, all limited by the
// single-port key memory. Each result is then moved to the output register.
// Reset loads two keys (time 0 black, time 1.0 white), min_spacing 66, and
// empties the output register. When the receiver stalls, the held result
// stays on m_tdata; the block still takes and processes the next item and
// waits with its result until the output register frees.
module color_gradient_table_sampler_core #(
	parameter int MAX_KEYS = cgts_pkg::MAX_KEYS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// action[2:0], time_in[18:3], key_index[26:19], red_in[42:27],
	// green_in[58:43], blue_in[74:59], alpha_in[90:75], zero fill
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cgts_pkg::S_DATA_W-1:0]     s_tdata,
	// status[1:0], time_out[17:2], red_out[33:18], green_out[49:34],
	// blue_out[65:50], alpha_out[81:66], key_count[90:82], zero fill
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cgts_pkg::M_DATA_W-1:0]     m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cgts_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [cgts_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [cgts_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import cgts_pkg::*;

	logic [COLOR_W-1:0] left_color_q, right_color_q;
	logic [TIME_W-1:0]  min_spacing_q;
	cmd_t               cmd;
	sts_t               sts;

	assign pready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_color_q  <= LEFT_RESET;
			right_color_q <= RIGHT_RESET;
			min_spacing_q <= SPACING_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[4:3])
				REG_LEFT:    left_color_q  <= pwdata;
				REG_RIGHT:   right_color_q <= pwdata;
				REG_SPACING: min_spacing_q <= pwdata[TIME_W-1:0];
				default:     ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (paddr[4:3])
			REG_LEFT:    prdata = left_color_q;
			REG_RIGHT:   prdata = right_color_q;
			REG_SPACING: prdata = APB_DATA_W'(min_spacing_q);
			default:     prdata = '0;
		endcase
	end

	cgts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cgts_datapath #(
		.MAX_KEYS (MAX_KEYS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.s_tdata     (s_tdata),
		.min_spacing (min_spacing_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

`ifndef ASSERT_OFF
	// The table never drops below two keys nor grows past its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[90:82] >= 9'd2) && (m_tdata[90:82] <= 9'(MAX_KEYS)))
		else $error("key count out of range");

	// No result carries the unused status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3))
		else $error("invalid status code");

	// Taking an item leaves the idle state at once
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while busy");
`endif

endmodule
